// File: hdl/etsfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etsfd_pkg
// Shared types and codes of the single-wire sensor frame decoder.
// ----------------------------------------------------------------------------
package etsfd_pkg;

  localparam int unsigned EDGE_TIME_W = 16;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned FRAME_LEN   = 40;
  localparam int unsigned BIT_CNT_W   = 6;

  // event codes
  localparam logic [1:0] MODE_ARM     = 2'd0;
  localparam logic [1:0] MODE_EDGE    = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_CHECKSUM = 2'd1;
  localparam logic [1:0] STAT_TIMING   = 2'd2;
  localparam logic [1:0] STAT_TIMEOUT  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX      = 3'd5;

  // reset window values in microseconds
  localparam logic [CFG_W-1:0] RESPONSE_MIN_RST = 16'd141;
  localparam logic [CFG_W-1:0] RESPONSE_MAX_RST = 16'd179;
  localparam logic [CFG_W-1:0] ZERO_MIN_RST     = 16'd60;
  localparam logic [CFG_W-1:0] ZERO_MAX_RST     = 16'd90;
  localparam logic [CFG_W-1:0] ONE_MIN_RST      = 16'd110;
  localparam logic [CFG_W-1:0] ONE_MAX_RST      = 16'd140;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_RECV = 3'b100
  } phase_t;

endpackage : etsfd_pkg
`default_nettype wire

// File: hdl/etsfd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etsfd interfaces
// Valid/ready channels for edge events and decoded frame results.
// ----------------------------------------------------------------------------
interface etsfd_event_if
  import etsfd_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [EDGE_TIME_W-1:0] edge_time;

  modport source (output valid, output mode, output edge_time, input ready);
  modport sink   (input valid, input mode, input edge_time, output ready);
endinterface : etsfd_event_if

interface etsfd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] humidity_int;
  logic [7:0] humidity_frac;
  logic [7:0] temp_int;
  logic [7:0] temp_frac;

  modport source (output valid, output status, output humidity_int,
                  output humidity_frac, output temp_int, output temp_frac,
                  input ready);
  modport sink   (input valid, input status, input humidity_int,
                  input humidity_frac, input temp_int, input temp_frac,
                  output ready);
endinterface : etsfd_result_if
`default_nettype wire

// File: hdl/edge_timed_sensor_frame_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edge_timed_sensor_frame_decoder_top
// Decodes a single-wire humidity/temperature sensor frame from edge times.
// ----------------------------------------------------------------------------
// Each event beat (arm, falling edge or timeout) lands in an input register,
// is decoded against the gap windows and the decoder state, and any result
// goes to an output register. One event is accepted per clock, also while a
// result waits to be taken, as long as the output register is free or drains
// in that cycle. Frame bits arrive MSB first; after 40 bits a result carries
// the four data bytes and status ok or checksum mismatch. Bit timing errors
// and timeouts while busy give a result with zero data. Windows are inclusive;
// gaps are taken modulo 2^TIME_BITS. The user must let configuration writes
// go in only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module edge_timed_sensor_frame_decoder_top
  import etsfd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  etsfd_event_if.sink               ev,
  etsfd_result_if.source            res
);

  localparam int unsigned CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  // configuration
  logic [CFG_W-1:0] response_min, response_max;
  logic [CFG_W-1:0] zero_min, zero_max;
  logic [CFG_W-1:0] one_min, one_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_min <= RESPONSE_MIN_RST;
      response_max <= RESPONSE_MAX_RST;
      zero_min     <= ZERO_MIN_RST;
      zero_max     <= ZERO_MAX_RST;
      one_min      <= ONE_MIN_RST;
      one_max      <= ONE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESPONSE_MIN: response_min <= cfg_data;
        REG_RESPONSE_MAX: response_max <= cfg_data;
        REG_ZERO_MIN:     zero_min     <= cfg_data;
        REG_ZERO_MAX:     zero_max     <= cfg_data;
        REG_ONE_MIN:      one_min      <= cfg_data;
        REG_ONE_MAX:      one_max      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                   evq_valid;
  logic [1:0]             evq_mode;
  logic [EDGE_TIME_W-1:0] evq_time;
  logic                   proc_fire;

  assign proc_fire = evq_valid && (!res.valid || res.ready);
  assign ev.ready  = !evq_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      evq_valid <= 1'b0;
    end else if (ev.ready) begin
      evq_valid <= ev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.valid && ev.ready) begin
      evq_mode <= ev.mode;
      evq_time <= ev.edge_time;
    end
  end

  // decoder state
  phase_t                 phase, phase_next;
  logic [TIME_BITS-1:0]   last_edge_time, last_edge_time_next;
  logic [BIT_CNT_W-1:0]   bits_received, bits_received_next;
  logic [FRAME_LEN-1:0]   frame_bits, frame_bits_next;

  logic [CMP_W-1:0]       now_wide;
  logic [TIME_BITS-1:0]   now_t;
  logic [TIME_BITS-1:0]   gap;
  logic [CMP_W-1:0]       gap_w;
  logic                   in_resp, in_zero, in_one;
  logic [BIT_CNT_W-1:0]   bits_inc;
  logic [FRAME_LEN-1:0]   frame_shift;
  logic [7:0]             sum;

  logic                   emit;
  logic [1:0]             emit_status;
  logic                   emit_data;

  assign now_wide = CMP_W'(evq_time);
  assign now_t    = now_wide[TIME_BITS-1:0];
  assign gap      = now_t - last_edge_time;
  assign gap_w    = CMP_W'(gap);

  assign in_resp = (gap_w >= CMP_W'(response_min)) && (gap_w <= CMP_W'(response_max));
  assign in_zero = (gap_w >= CMP_W'(zero_min)) && (gap_w <= CMP_W'(zero_max));
  assign in_one  = (gap_w >= CMP_W'(one_min)) && (gap_w <= CMP_W'(one_max));

  assign bits_inc    = bits_received + BIT_CNT_W'(1);
  // zero window wins where the two overlap
  assign frame_shift = {frame_bits[FRAME_LEN-2:0], !in_zero};
  assign sum = frame_shift[39:32] + frame_shift[31:24] + frame_shift[23:16]
             + frame_shift[15:8];

  always_comb begin
    phase_next          = phase;
    last_edge_time_next = last_edge_time;
    bits_received_next  = bits_received;
    frame_bits_next     = frame_bits;
    emit                = 1'b0;
    emit_status         = STAT_OK;
    emit_data           = 1'b0;
    case (evq_mode)
      MODE_ARM: begin
        last_edge_time_next = now_t;
        phase_next          = PH_WAIT;
      end
      MODE_TIMEOUT: begin
        if (phase != PH_IDLE) begin
          phase_next  = PH_IDLE;
          emit        = 1'b1;
          emit_status = STAT_TIMEOUT;
        end
      end
      MODE_EDGE: begin
        case (phase)
          PH_WAIT: begin
            last_edge_time_next = now_t;
            if (in_resp) begin
              phase_next         = PH_RECV;
              bits_received_next = '0;
              frame_bits_next    = '0;
            end
          end
          PH_RECV: begin
            last_edge_time_next = now_t;
            if (in_zero || in_one) begin
              frame_bits_next    = frame_shift;
              bits_received_next = bits_inc;
              if (bits_inc >= BIT_CNT_W'(FRAME_LEN)) begin
                phase_next  = PH_IDLE;
                emit        = 1'b1;
                emit_data   = 1'b1;
                emit_status = (sum == frame_shift[7:0]) ? STAT_OK : STAT_CHECKSUM;
              end
            end else begin
              phase_next  = PH_IDLE;
              emit        = 1'b1;
              emit_status = STAT_TIMING;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      last_edge_time <= '0;
      bits_received  <= '0;
      frame_bits     <= '0;
    end else if (proc_fire) begin
      phase          <= phase_next;
      last_edge_time <= last_edge_time_next;
      bits_received  <= bits_received_next;
      frame_bits     <= frame_bits_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (proc_fire && emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      res.status        <= emit_status;
      res.humidity_int  <= emit_data ? frame_shift[39:32] : 8'd0;
      res.humidity_frac <= emit_data ? frame_shift[31:24] : 8'd0;
      res.temp_int      <= emit_data ? frame_shift[23:16] : 8'd0;
      res.temp_frac     <= emit_data ? frame_shift[15:8]  : 8'd0;
    end
  end

endmodule : edge_timed_sensor_frame_decoder_top
`default_nettype wire
